// ===== src/sha512_pkg.sv =====
package sha512_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned RoundCount = 80;
  localparam logic [6:0] RoundLast = 7'(RoundCount - 1);

  typedef logic [WordW-1:0] word_t;
  typedef word_t [7:0] word_vec_t;

  typedef struct packed {
    logic word_in;
    logic round_init;
    logic round_step;
  } sha512_ctl_t;

  localparam word_vec_t InitHash = '{
    64'h5BE0CD19137E2179, 64'h1F83D9ABFB41BD6B, 64'h9B05688C2B3E6C1F, 64'h510E527FADE682D1,
    64'hA54FF53A5F1D36F1, 64'h3C6EF372FE94F82B, 64'hBB67AE8584CAA73B, 64'h6A09E667F3BCC908
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t round_k(logic [6:0] t);
    word_t k;
    unique case (t)
      7'd0:  k = 64'h428A2F98D728AE22;  7'd1:  k = 64'h7137449123EF65CD;
      7'd2:  k = 64'hB5C0FBCFEC4D3B2F;  7'd3:  k = 64'hE9B5DBA58189DBBC;
      7'd4:  k = 64'h3956C25BF348B538;  7'd5:  k = 64'h59F111F1B605D019;
      7'd6:  k = 64'h923F82A4AF194F9B;  7'd7:  k = 64'hAB1C5ED5DA6D8118;
      7'd8:  k = 64'hD807AA98A3030242;  7'd9:  k = 64'h12835B0145706FBE;
      7'd10: k = 64'h243185BE4EE4B28C;  7'd11: k = 64'h550C7DC3D5FFB4E2;
      7'd12: k = 64'h72BE5D74F27B896F;  7'd13: k = 64'h80DEB1FE3B1696B1;
      7'd14: k = 64'h9BDC06A725C71235;  7'd15: k = 64'hC19BF174CF692694;
      7'd16: k = 64'hE49B69C19EF14AD2;  7'd17: k = 64'hEFBE4786384F25E3;
      7'd18: k = 64'h0FC19DC68B8CD5B5;  7'd19: k = 64'h240CA1CC77AC9C65;
      7'd20: k = 64'h2DE92C6F592B0275;  7'd21: k = 64'h4A7484AA6EA6E483;
      7'd22: k = 64'h5CB0A9DCBD41FBD4;  7'd23: k = 64'h76F988DA831153B5;
      7'd24: k = 64'h983E5152EE66DFAB;  7'd25: k = 64'hA831C66D2DB43210;
      7'd26: k = 64'hB00327C898FB213F;  7'd27: k = 64'hBF597FC7BEEF0EE4;
      7'd28: k = 64'hC6E00BF33DA88FC2;  7'd29: k = 64'hD5A79147930AA725;
      7'd30: k = 64'h06CA6351E003826F;  7'd31: k = 64'h142929670A0E6E70;
      7'd32: k = 64'h27B70A8546D22FFC;  7'd33: k = 64'h2E1B21385C26C926;
      7'd34: k = 64'h4D2C6DFC5AC42AED;  7'd35: k = 64'h53380D139D95B3DF;
      7'd36: k = 64'h650A73548BAF63DE;  7'd37: k = 64'h766A0ABB3C77B2A8;
      7'd38: k = 64'h81C2C92E47EDAEE6;  7'd39: k = 64'h92722C851482353B;
      7'd40: k = 64'hA2BFE8A14CF10364;  7'd41: k = 64'hA81A664BBC423001;
      7'd42: k = 64'hC24B8B70D0F89791;  7'd43: k = 64'hC76C51A30654BE30;
      7'd44: k = 64'hD192E819D6EF5218;  7'd45: k = 64'hD69906245565A910;
      7'd46: k = 64'hF40E35855771202A;  7'd47: k = 64'h106AA07032BBD1B8;
      7'd48: k = 64'h19A4C116B8D2D0C8;  7'd49: k = 64'h1E376C085141AB53;
      7'd50: k = 64'h2748774CDF8EEB99;  7'd51: k = 64'h34B0BCB5E19B48A8;
      7'd52: k = 64'h391C0CB3C5C95A63;  7'd53: k = 64'h4ED8AA4AE3418ACB;
      7'd54: k = 64'h5B9CCA4F7763E373;  7'd55: k = 64'h682E6FF3D6B2B8A3;
      7'd56: k = 64'h748F82EE5DEFB2FC;  7'd57: k = 64'h78A5636F43172F60;
      7'd58: k = 64'h84C87814A1F0AB72;  7'd59: k = 64'h8CC702081A6439EC;
      7'd60: k = 64'h90BEFFFA23631E28;  7'd61: k = 64'hA4506CEBDE82BDE9;
      7'd62: k = 64'hBEF9A3F7B2C67915;  7'd63: k = 64'hC67178F2E372532B;
      7'd64: k = 64'hCA273ECEEA26619C;  7'd65: k = 64'hD186B8C721C0C207;
      7'd66: k = 64'hEADA7DD6CDE0EB1E;  7'd67: k = 64'hF57D4F7FEE6ED178;
      7'd68: k = 64'h06F067AA72176FBA;  7'd69: k = 64'h0A637DC5A2C898A6;
      7'd70: k = 64'h113F9804BEF90DAE;  7'd71: k = 64'h1B710B35131C471B;
      7'd72: k = 64'h28DB77F523047D84;  7'd73: k = 64'h32CAAB7B40C72493;
      7'd74: k = 64'h3C9EBE0A15C9BEBC;  7'd75: k = 64'h431D67C49C100D4C;
      7'd76: k = 64'h4CC5D4BECB3E42B6;  7'd77: k = 64'h597F299CFC657E2A;
      7'd78: k = 64'h5FCB6FAB3AD6FAEC;  7'd79: k = 64'h6C44198C4A475817;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== src/sha512_sched.sv =====
module sha512_sched (
  input  logic                     clk,
  input  sha512_pkg::sha512_ctl_t  ctl,
  input  sha512_pkg::word_t        in_word,
  output sha512_pkg::word_t        w_out
);
  import sha512_pkg::*;

  word_t win_r [16];
  word_t win_nxt;
  word_t s0;
  word_t s1;

  always_comb begin
    s0 = rotr(win_r[1], 1) ^ rotr(win_r[1], 8) ^ (win_r[1] >> 7);
    s1 = rotr(win_r[14], 19) ^ rotr(win_r[14], 61) ^ (win_r[14] >> 6);
    win_nxt = ctl.word_in ? in_word : (s1 + win_r[9] + s0 + win_r[0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.word_in || ctl.round_step) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= win_nxt;
    end
  end

  assign w_out = win_r[0];

endmodule

// ===== src/sha512_round.sv =====
module sha512_round (
  input  logic                     clk,
  input  sha512_pkg::sha512_ctl_t  ctl,
  input  logic [6:0]               round_idx,
  input  sha512_pkg::word_t        w_in,
  input  sha512_pkg::word_vec_t    chain,
  output sha512_pkg::word_vec_t    vars
);
  import sha512_pkg::*;

  word_vec_t vars_r;
  word_t     t1;
  word_t     t2;
  word_t     a, b, c, d, e, f, g, h;

  always_comb begin
    a = vars_r[0]; b = vars_r[1]; c = vars_r[2]; d = vars_r[3];
    e = vars_r[4]; f = vars_r[5]; g = vars_r[6]; h = vars_r[7];
    t1 = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + (g ^ (e & (f ^ g)))
           + round_k(round_idx) + w_in;
    t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) | (c & (a | b)));
  end

  always_ff @(posedge clk) begin
    if (ctl.round_init) begin
      vars_r <= chain;
    end else if (ctl.round_step) begin
      vars_r[7] <= g;
      vars_r[6] <= f;
      vars_r[5] <= e;
      vars_r[4] <= d + t1;
      vars_r[3] <= c;
      vars_r[2] <= b;
      vars_r[1] <= a;
      vars_r[0] <= t1 + t2;
    end
  end

  assign vars = vars_r;

endmodule

// ===== src/sha512_block_hash.sv =====
// SHA-512 compression core. Feed the padded message as 64-bit words, most significant word of
// each 1024-bit block first; in_tuser[0] on a block's first word loads the initial hash, and
// in_tuser[1] on a block's sixteenth word marks the message's last block. Words one to fifteen
// of a block are taken one per cycle. The sixteenth word starts the compression: one shared
// round unit runs the 80 rounds at one per cycle, then S_ADD adds the result into the chaining
// value; in_tready is low through both. After a final block the eight digest words follow
// as items, H0 first, with out_tlast on H7, and no input is taken until the last one is
// delivered.
module sha512_block_hash (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  sha512_pkg::word_t        in_tdata,   // msg_word
  input  logic [1:0]               in_tuser,   // msg_start, final_block
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output sha512_pkg::word_t        out_tdata,  // digest_word
  output logic [2:0]               out_tuser,  // word_index
  output logic                     out_tlast   // last_word
);
  import sha512_pkg::*;

  typedef enum logic [1:0] {
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  localparam logic [3:0] BlockLast = 4'd15;
  localparam logic [2:0] DigestLast = 3'd7;

  state_t      state_r;
  state_t      state_nxt;
  logic [3:0]  word_count_r;
  logic [6:0]  round_r;
  logic [2:0]  out_idx_r;
  logic        final_r;
  word_vec_t   chain_r;
  word_vec_t   vars;
  word_t       w;
  sha512_ctl_t ctl;
  logic        in_acc;
  logic        out_acc;

  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_acc   = out_tvalid && out_tready;
  assign out_tdata = chain_r[out_idx_r];
  assign out_tuser = out_idx_r;
  assign out_tlast = (out_idx_r == DigestLast);

  always_comb begin
    ctl.word_in    = in_acc;
    ctl.round_init = in_acc && (word_count_r == BlockLast);
    ctl.round_step = (state_r == S_ROUND);
  end

  sha512_sched u_sched (
    .clk     (clk),
    .ctl     (ctl),
    .in_word (in_tdata),
    .w_out   (w)
  );

  sha512_round u_round (
    .clk       (clk),
    .ctl       (ctl),
    .round_idx (round_r),
    .w_in      (w),
    .chain     (chain_r),
    .vars      (vars)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:  if (ctl.round_init) state_nxt = S_ROUND;
      S_ROUND: if (round_r == RoundLast) state_nxt = S_ADD;
      S_ADD:   state_nxt = final_r ? S_OUT : S_LOAD;
      S_OUT:   if (out_acc && out_tlast) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      word_count_r <= '0;
      round_r      <= '0;
      out_idx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        word_count_r <= word_count_r + 4'd1;
      end
      if (ctl.round_init) begin
        round_r <= '0;
      end else if (ctl.round_step) begin
        round_r <= round_r + 7'd1;
      end
      if (out_acc) begin
        out_idx_r <= out_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && word_count_r == '0 && in_tuser[0]) begin
      chain_r <= InitHash;
    end else if (state_r == S_ADD) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_r[i] + vars[i];
      end
    end
    if (ctl.round_init) begin
      final_r <= in_tuser[1];
    end
  end

  a_no_input_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while digest pending");

  a_block_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && word_count_r == BlockLast) |=> (!in_tready && round_r == '0))
    else $error("sixteenth word did not start rounds");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (round_r <= RoundLast))
    else $error("round counter overrun");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (in_tready && out_idx_r == '0))
    else $error("digest end did not release input");

endmodule

// ===== sim/sha512_block_hash_check.sv =====
`timescale 1ns / 100ps

module sha512_block_hash_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  sha512_pkg::word_t in_tdata,   // msg_word
  input  logic [1:0]        in_tuser,   // msg_start, final_block
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  sha512_pkg::word_t out_tdata,  // digest_word
  input  logic [2:0]        out_tuser,  // word_index
  input  logic              out_tlast,  // last_word
  output int                mismatches,
  output int                digests_due,
  output int                digest_words
);

  import sha512_pkg::word_t;

  localparam logic [0:79][63:0] RoundK = {
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
    64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
    64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
    64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
    64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
    64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
    64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
    64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
    64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
    64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
    64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
    64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
    64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
    64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
  };

  localparam logic [0:7][63:0] StartHash = {
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  typedef struct packed {
    word_t      digest;
    logic [2:0] index;
    logic       last;
  } digest_item_t;

  word_t        chain_h [8];
  word_t        sched   [16];
  logic [3:0]   word_pos;
  digest_item_t pending_digest [$];

  function automatic word_t ror(word_t x, int n);
    logic [127:0] both;
    both = {x, x} >> n;
    return both[63:0];
  endfunction

  task automatic compress_block();
    word_t v [8];
    word_t w, t1, t2, s0, s1;
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        w = sched[t];
      end else begin
        s0 = ror(sched[(t + 1) % 16], 1) ^ ror(sched[(t + 1) % 16], 8) ^
             (sched[(t + 1) % 16] >> 7);
        s1 = ror(sched[(t + 14) % 16], 19) ^ ror(sched[(t + 14) % 16], 61) ^
             (sched[(t + 14) % 16] >> 6);
        w = s1 + sched[(t + 9) % 16] + s0 + sched[t % 16];
        sched[t % 16] = w;
      end
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41)) +
           (v[6] ^ (v[4] & (v[5] ^ v[6]))) + RoundK[t] + w;
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39)) +
           ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endtask

  task automatic absorb_word(word_t data, logic start, logic last_block);
    digest_item_t item;
    if (word_pos == 4'd0 && start) begin
      for (int i = 0; i < 8; i++) chain_h[i] = StartHash[i];
    end
    sched[word_pos] = data;
    if (word_pos == 4'd15) begin
      compress_block();
      if (last_block) begin
        for (int i = 0; i < 8; i++) begin
          item.digest = chain_h[i];
          item.index  = 3'(i);
          item.last   = (i == 7);
          pending_digest.push_back(item);
        end
      end
    end
    word_pos = word_pos + 4'd1;
  endtask

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    digest_item_t want;
    if (!rst_n) begin
      word_pos = 4'd0;
      pending_digest.delete();
      mismatches = 0;
      digest_words = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        digest_words++;
        if (pending_digest.size() == 0) begin
          report_mismatch($sformatf("unexpected digest item %h index %0d", out_tdata,
                                    out_tuser));
        end else begin
          want = pending_digest.pop_front();
          if (out_tdata !== want.digest)
            report_mismatch($sformatf("digest word %0d got %h want %h", want.index,
                                      out_tdata, want.digest));
          if (out_tuser !== want.index)
            report_mismatch($sformatf("word index got %0d want %0d", out_tuser,
                                      want.index));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("tlast on word %0d got %b want %b", want.index,
                                      out_tlast, want.last));
        end
      end
      if (in_tvalid && in_tready) absorb_word(in_tdata, in_tuser[0], in_tuser[1]);
    end
    digests_due = pending_digest.size();
  end

endmodule

// ===== sim/sha512_block_hash_test.sv =====
`timescale 1ns / 100ps

module sha512_block_hash_test;

  import sha512_pkg::word_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  word_t      in_tdata;    // msg_word
  logic [1:0] in_tuser;    // msg_start, final_block
  logic       out_tvalid;
  logic       out_tready;
  word_t      out_tdata;   // digest_word
  logic [2:0] out_tuser;   // word_index
  logic       out_tlast;   // last_word
  int         mismatches;
  int         digests_due;
  int         digest_words;
  int         words_sent;
  int         blocks_sent;
  int         finals_sent;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sha512_block_hash dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  sha512_block_hash_check check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .digests_due (digests_due),
    .digest_words(digest_words)
  );

  function automatic word_t pick_word();
    word_t w;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2: w = word_t'(1) << $urandom_range(0, 63);
      3: w = ~(word_t'(1) << $urandom_range(0, 63));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic send_word(word_t data, logic start, logic last_block, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= {last_block, start};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_block(bit start, bit last_block, bit noisy, bit burst);
    bit s, f;
    for (int w = 0; w < 16; w++) begin
      s = (w == 0) ? start : (noisy && $urandom_range(0, 3) == 0);
      f = (w == 15) ? last_block : (noisy && $urandom_range(0, 3) == 0);
      send_word(pick_word(), s, f, burst);
    end
    blocks_sent++;
    if (last_block) finals_sent++;
  endtask

  initial begin
    int stall;
    bit calm;
    calm = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if ($urandom_range(0, 5) == 0) calm = !calm;
    end
  end

  initial begin
    words_sent  = 0;
    blocks_sent = 0;
    finals_sent = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, start flag off the first word, final flag off the sixteenth word
    for (int w = 0; w < 16; w++) begin
      send_word(w[0] ? '1 : '0, w == 0 || w == 6, w == 3 || w == 15, 1'b0);
    end
    blocks_sent++;
    finals_sent++;

    while (words_sent < 300) begin
      send_block($urandom_range(0, 2) != 0, $urandom_range(0, 1) != 0,
                 $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (digests_due != 0);
    repeat (120) @(posedge clk);

    $display("covered %0d words in %0d blocks, %0d of them final", words_sent, blocks_sent,
             finals_sent);
    $display("checked %0d digest items, %0d mismatches", digest_words, mismatches);
    if (mismatches == 0) begin
      $display("PASS sha512_block_hash");
    end else begin
      $display("FAIL sha512_block_hash");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL sha512_block_hash");
    $finish;
  end

endmodule

// ===== sha512_block_hash.f =====
src/sha512_pkg.sv
src/sha512_sched.sv
src/sha512_round.sv
src/sha512_block_hash.sv
sim/sha512_block_hash_check.sv
sim/sha512_block_hash_test.sv
